// ===== hw/rtl/slef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slef_pkg: shared types and constants of the line editor
// Character codes, the command word passed from front to back, back states.
// ----------------------------------------------------------------------------
package slef_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_GT    = 8'd62;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    typedef enum logic [1:0] {
        CMD_ECHO,
        CMD_PROMPT,
        CMD_ERASE,
        CMD_DUMP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
    } queue_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_FETCH,
        ST_SEND
    } back_state_t;

endpackage

// ===== hw/rtl/slef_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slef_rx_if / slef_tx_if: valid-ready channels of the line editor
// Receive channel carries one terminal byte, transmit channel one result.
// ----------------------------------------------------------------------------
interface slef_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slef_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output out_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input out_kind,
                    input last_of_run, output ready);
endinterface

// ===== hw/rtl/slef_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slef_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/slef_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slef_queue: two-word command queue between front and back
// Lets the front take a new byte while the back is still emitting.
// ----------------------------------------------------------------------------
module slef_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  slef_pkg::queue_word_t wr_word,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output slef_pkg::queue_word_t rd_word
);
    import slef_pkg::*;

    queue_word_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_word  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

// ===== hw/rtl/slef_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slef_front: byte classifier and line keeper
// Accepts received bytes, updates the fill count, stores all but CR, LF, BS
// and DEL if not full, and queues one command word per byte causing output.
// ----------------------------------------------------------------------------
module slef_front #(
    parameter int LINE_DEPTH = slef_pkg::LINE_DEPTH_DEF,
    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
    localparam int LEN_W  = $clog2(LINE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    slef_rx_if.sink               rx,
    output logic                  q_valid,
    input  logic                  q_ready,
    output slef_pkg::queue_word_t q_word,
    output logic                  ram_we,
    output logic [ADDR_W-1:0]     ram_waddr,
    output logic [7:0]            ram_wdata,
    output logic [LEN_W-1:0]      dump_len,
    input  logic                  dump_done
);
    import slef_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] dump_len_reg, dump_len_next;
    logic             pending_reg, pending_next;
    logic             accept;
    logic             has_room;

    // Hold off new bytes while a dump still reads the line store.
    assign rx.ready  = q_ready && !pending_reg;
    assign accept    = rx.valid && rx.ready;
    assign has_room  = (len_reg < LEN_W'(LINE_DEPTH));
    assign ram_waddr = len_reg[ADDR_W-1:0];
    assign ram_wdata = rx.rx_byte;
    assign dump_len  = dump_len_reg;

    always_comb
    begin
        len_next      = len_reg;
        dump_len_next = dump_len_reg;
        pending_next  = dump_done ? 1'b0 : pending_reg;
        q_valid       = 1'b0;
        q_word.kind   = CMD_ECHO;
        q_word.data   = rx.rx_byte;
        ram_we        = 1'b0;
        if (accept)
        begin
            if (rx.rx_byte == CHAR_CR)
            begin
                q_valid = 1'b1;
                if (len_reg != '0)
                begin
                    q_word.kind   = CMD_DUMP;
                    dump_len_next = len_reg;
                    len_next      = '0;
                    pending_next  = 1'b1;
                end
                else
                begin
                    q_word.kind = CMD_PROMPT;
                end
            end
            else if (rx.rx_byte == CHAR_BS || rx.rx_byte == CHAR_DEL)
            begin
                if (len_reg != '0)
                begin
                    q_valid     = 1'b1;
                    q_word.kind = CMD_ERASE;
                    len_next    = len_reg - LEN_W'(1);
                end
            end
            else if (rx.rx_byte != CHAR_LF)
            begin
                q_valid = 1'b1;
                if (has_room)
                begin
                    ram_we   = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dump_len_reg <= dump_len_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_DEPTH))
        else $error("fill count above line depth");

    a_cr_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx.rx_byte == CHAR_CR && len_reg != '0)
            |=> (len_reg == '0 && pending_reg && !rx.ready))
        else $error("line not cleared or input not held after dump");

    a_no_write_during_dump: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> !ram_we)
        else $error("line store written while a dump is pending");

endmodule

// ===== hw/rtl/slef_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slef_back: result sequencer
// Expands each command word into its echo bytes or walks the line store,
// one result at a time into a registered output.
// ----------------------------------------------------------------------------
module slef_back #(
    parameter int LINE_DEPTH = slef_pkg::LINE_DEPTH_DEF,
    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
    localparam int LEN_W  = $clog2(LINE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  slef_pkg::queue_word_t q_word,
    output logic [ADDR_W-1:0]     ram_raddr,
    input  logic [7:0]            ram_rdata,
    input  logic [LEN_W-1:0]      dump_len,
    output logic                  dump_done,
    slef_tx_if.source             tx
);
    import slef_pkg::*;

    back_state_t      state_reg, state_next;
    cmd_kind_t        kind_reg, kind_next;
    logic [7:0]       data_reg, data_next;
    logic [LEN_W-1:0] step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_kind_reg;
    logic             out_last_reg;
    logic             free;
    logic             load;
    logic [7:0]       load_byte;
    logic             load_kind;
    logic             load_last;

    function automatic logic [7:0] seq_byte(cmd_kind_t kind, logic [1:0] step,
                                            logic [7:0] data);
        logic [7:0] b;
        begin
            b = data;
            case (kind)
                CMD_PROMPT:
                begin
                    case (step)
                        2'd0:    b = CHAR_CR;
                        2'd1:    b = CHAR_LF;
                        2'd2:    b = CHAR_GT;
                        default: b = CHAR_SPACE;
                    endcase
                end
                CMD_ERASE:
                begin
                    b = (step == 2'd1) ? CHAR_SPACE : CHAR_BS;
                end
                default: b = data;
            endcase
            return b;
        end
    endfunction

    function automatic logic seq_last(cmd_kind_t kind, logic [1:0] step);
        logic l;
        begin
            case (kind)
                CMD_PROMPT: l = (step == 2'd3);
                CMD_ERASE:  l = (step == 2'd2);
                default:    l = 1'b1;
            endcase
            return l;
        end
    endfunction

    assign free      = !out_valid_reg || tx.ready;
    assign ram_raddr = step_reg[ADDR_W-1:0];

    assign tx.valid       = out_valid_reg;
    assign tx.out_byte    = out_byte_reg;
    assign tx.out_kind    = out_kind_reg;
    assign tx.last_of_run = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        data_next  = data_reg;
        step_next  = step_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        load_byte  = ram_rdata;
        load_kind  = 1'b0;
        load_last  = 1'b0;
        dump_done  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_word.kind;
                    data_next  = q_word.data;
                    step_next  = '0;
                    state_next = (q_word.kind == CMD_DUMP) ? ST_FETCH : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (free)
                begin
                    load      = 1'b1;
                    load_byte = seq_byte(kind_reg, step_reg[1:0], data_reg);
                    load_last = seq_last(kind_reg, step_reg[1:0]);
                    if (load_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + LEN_W'(1);
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (free)
                begin
                    load      = 1'b1;
                    load_kind = 1'b1;
                    load_last = ((step_reg + LEN_W'(1)) == dump_len);
                    if (load_last)
                    begin
                        dump_done  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next  = step_reg + LEN_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
        step_reg <= step_next;
        if (load)
        begin
            out_byte_reg <= load_byte;
            out_kind_reg <= load_kind;
            out_last_reg <= load_last;
        end
    end

    a_fetch_then_send: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |=> state_reg == ST_SEND)
        else $error("line store read not followed by send");

    a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        dump_done |=> (out_valid_reg && out_last_reg && out_kind_reg))
        else $error("dump end without a marked command word");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command popped while busy");

endmodule

// ===== hw/rtl/serial_line_editor_echo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_echo: terminal line editor with echo
// Keeps an edit line of received bytes and echoes or dumps it.
// ----------------------------------------------------------------------------
// Usage:
//   rx is a valid-ready sink of received terminal bytes; tx is a valid-ready
//   source of result words: out_byte, out_kind (0 echo, 1 command byte) and
//   last_of_run on the final word caused by one received byte.
//   Line feed, and backspace or delete on an empty line, give no word.
// Flow:
//   A result word passes the queue, the sequencer state and the output
//   register before it shows on tx.valid; a dump adds the registered line
//   store read. The sequencer takes commands from the queue only when idle,
//   and emits all words of one command before it takes the next.
//   rx stays low from a dump-causing carriage return until the
//   last command word of that dump is loaded, since the line store is busy.
//   A two-word queue between classifier and sequencer lets rx take bytes
//   while earlier words still wait on tx.
// Reset:
//   rst_n clears the fill count, the queue and the output valid flag; the
//   line store keeps its contents and needs no clearing pass.
// Stall:
//   When tx.ready is low the output word holds, the sequencer stops, the
//   queue fills and then rx.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module serial_line_editor_echo #(
    parameter int LINE_DEPTH = slef_pkg::LINE_DEPTH_DEF,
    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
    localparam int LEN_W  = $clog2(LINE_DEPTH + 1)
) (
    input  logic       clk,
    input  logic       rst_n,
    slef_rx_if.sink    rx,
    slef_tx_if.source  tx
);
    import slef_pkg::*;

    // Front to queue
    logic        fq_valid;
    logic        fq_ready;
    queue_word_t fq_word;

    // Queue to back
    logic        qb_valid;
    logic        qb_pop;
    queue_word_t qb_word;

    // Line store ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Dump handoff: length is held by the front until the back reports done
    logic [LEN_W-1:0]  dump_len;
    logic              dump_done;

    // Classify bytes, keep the fill count, write the line store
    slef_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_word    (fq_word),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .dump_len  (dump_len),
        .dump_done (dump_done)
    );

    // Decouple classification from emission
    slef_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_word  (fq_word),
        .rd_valid (qb_valid),
        .rd_ready (qb_pop),
        .rd_word  (qb_word)
    );

    // Edit line storage
    slef_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Expand commands into result words
    slef_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_pop     (qb_pop),
        .q_word    (qb_word),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .dump_len  (dump_len),
        .dump_done (dump_done),
        .tx        (tx)
    );

endmodule

// ===== test/serial_line_editor_echo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_echo_checker: scoreboard of the line editor bench
// Watches both channels, keeps its own copy of the edit line, predicts the
// words each received byte causes and compares every transmitted word.
// ----------------------------------------------------------------------------
module serial_line_editor_echo_checker #(
    parameter int LINE_DEPTH = slef_pkg::LINE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    slef_rx_if          rx,
    slef_tx_if          tx,
    output int unsigned fail_count,
    output int unsigned words_pending,
    output int unsigned busy_bytes
);
    import slef_pkg::*;

    localparam logic KIND_ECHO    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;
    localparam int   REPORT_LIMIT = 10;

    typedef struct {
        logic [7:0] data;
        logic       kind;
        logic       last;
    } tx_word_t;

    tx_word_t    expected_words[$];
    logic [7:0]  line_chars[LINE_DEPTH];
    int unsigned line_fill;

    function automatic void push_word(input logic [7:0] data, input logic kind);
        tx_word_t w;
        w.data = data;
        w.kind = kind;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    // Apply one received byte to the edit line; queue the words it causes and return their number.
    function automatic int unsigned edit_line(input logic [7:0] c);
        int unsigned count;
        int unsigned i;
        count = 0;
        if (c == CHAR_CR)
        begin
            if (line_fill > 0)
            begin
                for (i = 0; i < line_fill; i++)
                begin
                    push_word(line_chars[i], KIND_COMMAND);
                end
                count = line_fill;
                line_fill = 0;
            end
            else
            begin
                push_word(CHAR_CR, KIND_ECHO);
                push_word(CHAR_LF, KIND_ECHO);
                push_word(CHAR_GT, KIND_ECHO);
                push_word(CHAR_SPACE, KIND_ECHO);
                count = 4;
            end
        end
        else if (c == CHAR_BS || c == CHAR_DEL)
        begin
            if (line_fill > 0)
            begin
                line_fill--;
                push_word(CHAR_BS, KIND_ECHO);
                push_word(CHAR_SPACE, KIND_ECHO);
                push_word(CHAR_BS, KIND_ECHO);
                count = 3;
            end
        end
        else if (c != CHAR_LF)
        begin
            push_word(c, KIND_ECHO);
            count = 1;
            if (line_fill < LINE_DEPTH)
            begin
                line_chars[line_fill] = c;
                line_fill++;
            end
        end
        if (count > 0)
        begin
            expected_words[expected_words.size() - 1].last = 1'b1;
        end
        return count;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_words
        tx_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            line_fill = 0;
            fail_count <= 0;
            words_pending <= 0;
            busy_bytes <= 0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                if (edit_line(rx.rx_byte) > 0)
                begin
                    busy_bytes <= busy_bytes + 1;
                end
            end
            if (tx.valid && tx.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected word: byte %02h kind %0d last %0d",
                                 $time, tx.out_byte, tx.out_kind, tx.last_of_run);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (tx.out_byte !== want.data || tx.out_kind !== want.kind ||
                        tx.last_of_run !== want.last)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                                     $time, want.data, want.kind, want.last,
                                     tx.out_byte, tx.out_kind, tx.last_of_run);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

// ===== test/serial_line_editor_echo_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_echo_tb: stimulus and verdict for the line editor
// Types directed and random terminal traffic into the editor, stalls the
// transmit side at random, and leaves all word checking to the checker.
// ----------------------------------------------------------------------------
module serial_line_editor_echo_tb;
    import slef_pkg::*;

    localparam int          LINE_DEPTH     = LINE_DEPTH_DEF;
    localparam int unsigned ITEM_TARGET    = 410;
    localparam int unsigned DRAIN_CYCLES   = 20;
    // Longest legal quiet stretch is one long gap plus the pipeline latency,
    // so reaching WATCHDOG_LIMIT with no handshake means the block is stuck.
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    logic clk;
    logic rst_n;

    slef_rx_if rx_ch ();
    slef_tx_if tx_ch ();

    int unsigned fail_count;
    int unsigned words_pending;
    int unsigned busy_bytes;
    int unsigned quiet_cycles;
    logic        steady_flow = 1'b0;

    serial_line_editor_echo #(
        .LINE_DEPTH (LINE_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    serial_line_editor_echo_checker #(
        .LINE_DEPTH (LINE_DEPTH)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .tx            (tx_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .busy_bytes    (busy_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    // While steady_flow is set both sides run back to back.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Any byte that lands in the line: mostly printable, sometimes any
    // other value that is not one of the four control characters.
    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 70)
            return 8'($urandom_range(32, 126));
        c = 8'($urandom_range(0, 255));
        while (c == CHAR_CR || c == CHAR_LF || c == CHAR_BS || c == CHAR_DEL)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Offer one byte and return at the edge that accepts it. valid stays
    // high on return; the caller either offers the next byte in the same
    // step or drops valid.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
    endtask

    // Type a line of len characters, sprinkle erases at edit_pct percent,
    // and close it with a carriage return.
    task automatic send_command(input int unsigned len, input int unsigned edit_pct);
        int unsigned k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 99) < edit_pct)
                send_byte(($urandom_range(0, 1) != 0) ? CHAR_BS : CHAR_DEL);
            send_byte(pick_text_char());
        end
        send_byte(CHAR_CR);
    endtask

    // Hold the sender until every predicted word has left the block.
    task automatic pause_until_drained();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
    endtask

    // Transmit side: ready runs of random length broken by random stalls.
    initial
    begin
        int unsigned run;
        int unsigned gap;
        tx_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            run = $urandom_range(1, 12);
            tx_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d words outstanding",
                         $time, words_pending);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned roll;
        int unsigned k;
        int unsigned n;

        rst_n = 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: fresh prompt, the silent bytes on an empty line,
        // both byte extremes stored, erase by backspace and by delete, a
        // short dump, then a prompt again to show the line was cleared.
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(CHAR_BS);
        send_byte(CHAR_DEL);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(CHAR_BS);
        send_byte(8'h80);
        send_byte(CHAR_DEL);
        send_byte(8'h7E);
        send_byte(CHAR_LF);
        send_byte(8'h01);
        send_byte(8'h20);
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        // One stored char: dump of a single command word.
        send_byte(8'h5A);
        send_byte(CHAR_CR);
        // Erase a line back to empty, then erase once more on empty.
        send_byte(8'h61);
        send_byte(CHAR_DEL);
        send_byte(CHAR_BS);
        send_byte(CHAR_CR);

        pause_until_drained();

        // Full line: overfill, erase the top char, refill it and dump the
        // whole LINE_DEPTH words in one run.
        for (k = 0; k < LINE_DEPTH + 3; k++)
            send_byte(pick_text_char());
        send_byte(CHAR_BS);
        send_byte(pick_text_char());
        send_byte(pick_text_char());
        send_byte(CHAR_CR);

        // Random traffic: mostly command lines with random content and a
        // few edits, some long lines near or past full, some bare prompts
        // and some raw noise that may hit any control character.
        while (busy_bytes < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                steady_flow <= !steady_flow;
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                send_command($urandom_range(1, 10), 12);
            end
            else if (roll < 61)
            begin
                send_command($urandom_range(LINE_DEPTH - 2, LINE_DEPTH + 6), 5);
            end
            else if (roll < 71)
            begin
                send_byte(($urandom_range(0, 1) != 0) ? CHAR_BS : CHAR_LF);
                send_byte(CHAR_CR);
            end
            else if (roll < 90)
            begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                pause_until_drained();
                send_command($urandom_range(1, 6), 0);
            end
        end

        // Drain: drop valid, wait for the last predicted word, then let the
        // pipeline run on so that any stray word shows.
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && words_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
